/* rtl/ilf_pkg.sv */
// ----------------------------------------------------------------------------
// ilf_pkg - shared types and constants of the incremental line fit
// Sample format, status and mode codes, request and result payloads.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ilf_pkg;

    // Sample and accumulator geometry
    localparam int SAMPLE_BITS   = 16;
    localparam int FRACTION_BITS = 8;
    localparam int COUNT_W       = 12;
    localparam int SUM_W         = 28;
    localparam int SQ_W          = 44;
    localparam int WORD_W        = 64;
    localparam int Q_W           = 32;

    localparam logic [COUNT_W-1:0] MAX_COUNT = 12'd4095;

    // Request modes (mode 3 behaves as a report)
    localparam logic [1:0] MODE_GIVEN_X = 2'd0;
    localparam logic [1:0] MODE_AUTO_X  = 2'd1;
    localparam logic [1:0] MODE_REPORT  = 2'd2;

    // Result status codes
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_FULL      = 2'd1;
    localparam logic [1:0] STATUS_NO_POINTS = 2'd2;

    typedef struct packed {
        logic [1:0]                    mode;
        logic signed [SAMPLE_BITS-1:0] x_value;
        logic signed [SAMPLE_BITS-1:0] y_value;
    } point_t;

    typedef struct packed {
        logic signed [Q_W-1:0]         slope;
        logic signed [Q_W-1:0]         intercept;
        logic signed [Q_W-1:0]         mid_fit;
        logic signed [Q_W-1:0]         residual;
        logic [Q_W-2:0]                peak_residual;
        logic [Q_W-2:0]                rms_residual;
        logic signed [SAMPLE_BITS-1:0] low_x;
        logic signed [SAMPLE_BITS-1:0] high_x;
        logic signed [SAMPLE_BITS-1:0] low_y;
        logic signed [SAMPLE_BITS-1:0] high_y;
        logic [COUNT_W-1:0]            point_count;
        logic [1:0]                    status;
    } result_t;

endpackage

`default_nettype wire

/* rtl/incremental_line_fit.sv */
// ----------------------------------------------------------------------------
// incremental_line_fit - incremental least-squares straight-line fit
// Accumulates point sums, refits slope and intercept after every point,
// tracks residuals and extremes, and reports the RMS residual on request.
// ----------------------------------------------------------------------------
// One request is worked on at a time; point_ready is high only while the
// sequencer is idle. All arithmetic runs on one shared bit-serial unit: a
// multiply ends once no set bit of its multiplier operand is left, and the
// slope division carries 16 extra fraction bits over the plain division. A
// point takes an accept step, ten multiplies and two divisions (the slope
// division is skipped when the x spread is zero). A report request runs a
// division and the square root; a refused point (count full) or a report
// with no points goes straight to the result step. A finished result sits
// in an output register, so the next request is accepted while it waits; a
// later result stalls only if the previous one has still not been taken.
`timescale 1ns / 1ps
`default_nettype none

module incremental_line_fit
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            point_valid,
    output logic                 point_ready,
    input  wire ilf_pkg::point_t point,
    output logic                 result_valid,
    input  wire logic            result_ready,
    output ilf_pkg::result_t     result
);

    localparam int F      = ilf_pkg::FRACTION_BITS;
    localparam int SB     = ilf_pkg::SAMPLE_BITS;
    localparam int W      = ilf_pkg::WORD_W;
    localparam int AUTO_W = ilf_pkg::COUNT_W + 1 + F;
    localparam logic [6:0] ITER_SLOPE = 7'd80;
    localparam logic [6:0] ITER_PLAIN = 7'd64;
    localparam logic [6:0] ITER_SQRT  = 7'd32;
    localparam logic [AUTO_W-1:0] AUTO_LIMIT = AUTO_W'((1 << (SB - 1)) - 1);

    typedef enum logic [14:0] {
        S_IDLE   = 15'h0001,
        S_XX     = 15'h0002,
        S_XY     = 15'h0004,
        S_NSXX   = 15'h0008,
        S_SXSX   = 15'h0010,
        S_NSXY   = 15'h0020,
        S_SXSY   = 15'h0040,
        S_SLOPE  = 15'h0080,
        S_SLSX   = 15'h0100,
        S_ICPT   = 15'h0200,
        S_FIT    = 15'h0400,
        S_RSQ    = 15'h0800,
        S_MID    = 15'h1000,
        S_RMSDIV = 15'h2000,
        S_SQRT   = 15'h4000
    } state_t;

    state_t state_reg;
    logic   arm_reg;

    // Fit state
    logic [ilf_pkg::COUNT_W-1:0]      count_reg;
    logic signed [ilf_pkg::SUM_W-1:0] sx_reg, sy_reg;
    logic signed [ilf_pkg::SQ_W-1:0]  sxx_reg, sxy_reg;
    logic [W-1:0]                     srr_reg;
    logic [30:0]                      peak_reg;
    logic signed [SB-1:0]             min_x_reg, max_x_reg, min_y_reg, max_y_reg;
    logic signed [31:0]               slope_reg, icpt_reg;

    // Working registers
    logic signed [SB-1:0] x_reg, y_reg;
    logic [W-1:0]         t1_reg, den_reg;
    logic [31:0]          mag_reg;
    logic signed [31:0]   residual_reg;
    logic [30:0]          rms_reg;
    logic [1:0]           status_reg;

    // Shared serial unit
    logic [W-1:0] acc_reg, opa_reg, opb_reg, rem_reg, quo_reg;
    logic         ovf_reg, neg_reg;
    logic [6:0]   cnt_reg;

    logic              result_valid_reg;
    ilf_pkg::result_t  result_reg;

    // Saturate a 64-bit signed value to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [W-1:0] v);
        logic signed [31:0] r;
        if (v > 64'sh0000_0000_7FFF_FFFF)
            r = 32'sh7FFF_FFFF;
        else if (v < -64'sh0000_0000_8000_0000)
            r = 32'sh8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

    // Signed, saturated quotient from magnitude quotient and overflow flag
    function automatic logic signed [31:0] div_sat(input logic [31:0] q,
                                                   input logic over,
                                                   input logic neg);
        logic signed [31:0] r;
        if (neg)
            r = (over || q > 32'h8000_0000) ? 32'sh8000_0000 : 32'(32'd0 - q);
        else
            r = (over || q[31]) ? 32'sh7FFF_FFFF : q;
        return r;
    endfunction

    function automatic logic [W-1:0] mag64(input logic [W-1:0] v);
        return v[W-1] ? W'(0 - v) : v;
    endfunction

    // Unit class of the current step
    logic is_mul, is_div, slope_skip;
    always_comb
    begin
        is_mul = state_reg inside {S_XX, S_XY, S_NSXX, S_SXSX, S_NSXY, S_SXSY,
                                   S_SLSX, S_FIT, S_RSQ, S_MID};
        is_div = state_reg inside {S_SLOPE, S_ICPT, S_RMSDIV};
        // Degenerate x spread: slope division skipped
        slope_skip = (state_reg == S_SLOPE) && (den_reg == '0);
    end

    // Request decode
    logic                 accept, mode_point, full;
    logic [AUTO_W-1:0]    auto_wide;
    logic signed [SB-1:0] x_in;
    always_comb
    begin
        accept     = point_valid && point_ready;
        mode_point = (point.mode == ilf_pkg::MODE_GIVEN_X) ||
                     (point.mode == ilf_pkg::MODE_AUTO_X);
        full       = count_reg >= ilf_pkg::MAX_COUNT;
        auto_wide  = AUTO_W'(count_reg + 1'b1) << F;
        if (point.mode == ilf_pkg::MODE_GIVEN_X)
            x_in = point.x_value;
        else if (auto_wide > AUTO_LIMIT)
            x_in = AUTO_LIMIT[SB-1:0];
        else
            x_in = auto_wide[SB-1:0];
    end

    // Multiply operand selection
    logic [W-1:0]       mul_a, mul_b;
    logic signed [SB:0] x_span;
    always_comb
    begin
        x_span = (SB+1)'(min_x_reg) + (SB+1)'(max_x_reg);
        mul_a  = W'(x_reg);
        mul_b  = W'(x_reg);
        case (state_reg)
            S_XX:    begin mul_a = W'(x_reg);     mul_b = W'(x_reg);       end
            S_XY:    begin mul_a = W'(y_reg);     mul_b = W'(x_reg);       end
            S_NSXX:  begin mul_a = W'(sxx_reg);   mul_b = W'(count_reg);   end
            S_SXSX:  begin mul_a = W'(sx_reg);    mul_b = W'(sx_reg);      end
            S_NSXY:  begin mul_a = W'(sxy_reg);   mul_b = W'(count_reg);   end
            S_SXSY:  begin mul_a = W'(sy_reg);    mul_b = W'(sx_reg);      end
            S_SLSX:  begin mul_a = W'(slope_reg); mul_b = W'(sx_reg);      end
            S_FIT:   begin mul_a = W'(slope_reg); mul_b = W'(x_reg);       end
            S_RSQ:   begin mul_a = W'(mag_reg);   mul_b = W'(mag_reg);     end
            S_MID:   begin mul_a = W'(slope_reg); mul_b = W'(x_span);      end
            default: begin mul_a = W'(x_reg);     mul_b = W'(x_reg);       end
        endcase
    end

    // Divide operand selection
    logic [W-1:0] div_num, div_den;
    logic         div_neg;
    logic [6:0]   div_iter;
    always_comb
    begin
        case (state_reg)
            S_SLOPE:
            begin
                div_num  = mag64(t1_reg);
                div_den  = mag64(den_reg);
                div_neg  = t1_reg[W-1] != den_reg[W-1];
                div_iter = ITER_SLOPE;
            end
            S_ICPT:
            begin
                div_num  = mag64(t1_reg);
                div_den  = W'(count_reg) << F;
                div_neg  = t1_reg[W-1];
                div_iter = ITER_PLAIN;
            end
            default:
            begin
                div_num  = srr_reg;
                div_den  = W'(count_reg);
                div_neg  = 1'b0;
                div_iter = ITER_PLAIN;
            end
        endcase
    end

    // One step of each serial unit
    logic [W:0]   div_rs, div_diff;
    logic         div_ge;
    logic [W-1:0] quo_step, sq_try;
    logic         sq_ge;
    logic         unit_done;
    always_comb
    begin
        div_rs    = {rem_reg, opa_reg[W-1]};
        div_diff  = div_rs - {1'b0, opb_reg};
        div_ge    = div_rs >= {1'b0, opb_reg};
        quo_step  = {quo_reg[W-2:0], div_ge};
        sq_try    = quo_reg + opb_reg;
        sq_ge     = rem_reg >= sq_try;
        unit_done = !arm_reg && (is_mul ? (opb_reg == '0) : (cnt_reg == '0));
    end

    // Finishing arithmetic of the fit, residual and mid-range value
    logic signed [W-1:0] fit_val, diff_val, mid_wide;
    logic signed [31:0]  res_val;
    logic [31:0]         res_mag;
    logic [W:0]          srr_sum;
    logic signed [31:0]  div_val;
    logic                out_free;
    logic                result_load;
    always_comb
    begin
        fit_val     = ($signed(acc_reg) >>> F) + W'(icpt_reg);
        diff_val    = (W'(y_reg) << (16 - F)) - fit_val;
        res_val     = sat32(diff_val);
        res_mag     = res_val[31] ? 32'(32'd0 - res_val) : res_val;
        srr_sum     = {1'b0, srr_reg} + {1'b0, acc_reg};
        mid_wide    = ($signed(acc_reg) >>> (F + 1)) + W'(icpt_reg);
        div_val     = div_sat(quo_reg[31:0], ovf_reg, neg_reg);
        out_free    = !result_valid_reg || result_ready;
        result_load = unit_done && (state_reg == S_MID) && out_free;
    end

    // Sequencer and datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            arm_reg          <= 1'b0;
            result_valid_reg <= 1'b0;
            count_reg        <= '0;
            sx_reg           <= '0;
            sy_reg           <= '0;
            sxx_reg          <= '0;
            sxy_reg          <= '0;
            srr_reg          <= '0;
            peak_reg         <= '0;
            min_x_reg        <= '0;
            max_x_reg        <= '0;
            min_y_reg        <= '0;
            max_y_reg        <= '0;
            slope_reg        <= '0;
            icpt_reg         <= '0;
        end
        else
        begin
            // Output register handshake
            if (result_load)
                result_valid_reg <= 1'b1;
            else if (result_valid_reg && result_ready)
                result_valid_reg <= 1'b0;

            if (state_reg == S_IDLE)
            begin
                if (accept)
                begin
                    arm_reg      <= 1'b1;
                    residual_reg <= '0;
                    rms_reg      <= '0;
                    if (mode_point && full)
                    begin
                        status_reg <= ilf_pkg::STATUS_FULL;
                        state_reg  <= S_MID;
                    end
                    else if (mode_point)
                    begin
                        status_reg <= ilf_pkg::STATUS_OK;
                        x_reg      <= x_in;
                        y_reg      <= point.y_value;
                        if (count_reg == '0 || x_in > max_x_reg)
                            max_x_reg <= x_in;
                        if (count_reg == '0 || x_in < min_x_reg)
                            min_x_reg <= x_in;
                        if (count_reg == '0 || point.y_value > max_y_reg)
                            max_y_reg <= point.y_value;
                        if (count_reg == '0 || point.y_value < min_y_reg)
                            min_y_reg <= point.y_value;
                        count_reg <= count_reg + 1'b1;
                        sx_reg    <= sx_reg + ilf_pkg::SUM_W'(x_in);
                        sy_reg    <= sy_reg + ilf_pkg::SUM_W'(point.y_value);
                        state_reg <= S_XX;
                    end
                    else if (count_reg == '0)
                    begin
                        status_reg <= ilf_pkg::STATUS_NO_POINTS;
                        state_reg  <= S_MID;
                    end
                    else
                    begin
                        status_reg <= ilf_pkg::STATUS_OK;
                        state_reg  <= S_RMSDIV;
                    end
                end
            end
            else if (arm_reg)
            begin
                // Load the shared unit for this step
                arm_reg <= slope_skip;
                if (is_mul)
                begin
                    acc_reg <= '0;
                    opa_reg <= mul_b[W-1] ? W'(0 - mul_a) : mul_a;
                    opb_reg <= mul_b[W-1] ? W'(0 - mul_b) : mul_b;
                end
                else if (is_div)
                begin
                    if (slope_skip)
                    begin
                        // Slope forced to zero
                        slope_reg <= '0;
                        state_reg <= S_SLSX;
                    end
                    opa_reg <= div_num;
                    opb_reg <= div_den;
                    neg_reg <= div_neg;
                    cnt_reg <= div_iter;
                    rem_reg <= '0;
                    quo_reg <= '0;
                    ovf_reg <= 1'b0;
                end
                else
                begin
                    rem_reg <= t1_reg;
                    quo_reg <= '0;
                    opb_reg <= W'(1) << (W - 2);
                    cnt_reg <= ITER_SQRT;
                end
            end
            else if (!unit_done)
            begin
                // One serial step
                if (is_mul)
                begin
                    if (opb_reg[0])
                        acc_reg <= acc_reg + opa_reg;
                    opa_reg <= opa_reg << 1;
                    opb_reg <= opb_reg >> 1;
                end
                else if (is_div)
                begin
                    rem_reg <= div_ge ? div_diff[W-1:0] : div_rs[W-1:0];
                    quo_reg <= quo_step;
                    opa_reg <= opa_reg << 1;
                    if (quo_step[32])
                        ovf_reg <= 1'b1;
                    cnt_reg <= cnt_reg - 1'b1;
                end
                else
                begin
                    if (sq_ge)
                    begin
                        rem_reg <= rem_reg - sq_try;
                        quo_reg <= (quo_reg >> 1) + opb_reg;
                    end
                    else
                    begin
                        quo_reg <= quo_reg >> 1;
                    end
                    opb_reg <= opb_reg >> 2;
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
            else
            begin
                // Step finished: take its result; the mid step waits unarmed
                arm_reg <= (state_reg != S_MID);
                case (state_reg)
                    S_XX:
                    begin
                        sxx_reg   <= sxx_reg + acc_reg[ilf_pkg::SQ_W-1:0];
                        state_reg <= S_XY;
                    end
                    S_XY:
                    begin
                        sxy_reg   <= sxy_reg + acc_reg[ilf_pkg::SQ_W-1:0];
                        state_reg <= S_NSXX;
                    end
                    S_NSXX:
                    begin
                        t1_reg    <= acc_reg;
                        state_reg <= S_SXSX;
                    end
                    S_SXSX:
                    begin
                        den_reg   <= t1_reg - acc_reg;
                        state_reg <= S_NSXY;
                    end
                    S_NSXY:
                    begin
                        t1_reg    <= acc_reg;
                        state_reg <= S_SXSY;
                    end
                    S_SXSY:
                    begin
                        t1_reg    <= t1_reg - acc_reg;
                        state_reg <= S_SLOPE;
                    end
                    S_SLOPE:
                    begin
                        slope_reg <= div_val;
                        state_reg <= S_SLSX;
                    end
                    S_SLSX:
                    begin
                        t1_reg    <= (W'(sy_reg) << 16) - acc_reg;
                        state_reg <= S_ICPT;
                    end
                    S_ICPT:
                    begin
                        icpt_reg  <= div_val;
                        state_reg <= S_FIT;
                    end
                    S_FIT:
                    begin
                        residual_reg <= res_val;
                        mag_reg      <= res_mag;
                        if (res_mag[31])
                            peak_reg <= 31'h7FFF_FFFF;
                        else if (res_mag[30:0] > peak_reg)
                            peak_reg <= res_mag[30:0];
                        state_reg <= S_RSQ;
                    end
                    S_RSQ:
                    begin
                        srr_reg   <= srr_sum[W] ? '1 : srr_sum[W-1:0];
                        state_reg <= S_MID;
                    end
                    S_RMSDIV:
                    begin
                        t1_reg    <= quo_reg;
                        state_reg <= S_SQRT;
                    end
                    S_SQRT:
                    begin
                        rms_reg   <= (quo_reg > W'(32'h7FFF_FFFF)) ? 31'h7FFF_FFFF
                                                                  : quo_reg[30:0];
                        state_reg <= S_MID;
                    end
                    S_MID:
                    begin
                        // Hold here until the output register is free
                        if (out_free)
                        begin
                            result_reg.slope         <= slope_reg;
                            result_reg.intercept     <= icpt_reg;
                            result_reg.mid_fit       <= sat32(mid_wide);
                            result_reg.residual      <= residual_reg;
                            result_reg.peak_residual <= peak_reg;
                            result_reg.rms_residual  <= rms_reg;
                            result_reg.low_x         <= min_x_reg;
                            result_reg.high_x        <= max_x_reg;
                            result_reg.low_y         <= min_y_reg;
                            result_reg.high_y        <= max_y_reg;
                            result_reg.point_count   <= count_reg;
                            result_reg.status        <= status_reg;
                            state_reg                <= S_IDLE;
                        end
                    end
                    default:
                    begin
                        state_reg <= S_IDLE;
                    end
                endcase
            end
        end
    end

    assign point_ready  = state_reg == S_IDLE;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // Checks
    a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= ilf_pkg::MAX_COUNT)
        else $error("point count beyond limit");

    a_peak_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        peak_reg >= $past(peak_reg))
        else $error("peak residual decreased");

    a_srr_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        srr_reg >= $past(srr_reg))
        else $error("squared residual sum decreased");

    a_x_order: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != '0) |-> (min_x_reg <= max_x_reg))
        else $error("x extremes out of order");

    a_iter_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (is_div && !arm_reg) |-> (cnt_reg <= ITER_SLOPE))
        else $error("divider iteration count out of range");

endmodule

`default_nettype wire
